// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of the event scheduler.
// Include this header by its bare name; it holds no other content.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on the rising clock edge, ignored while reset is low.
`define TES_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Implication checked on the rising clock edge, ignored while reset is low.
`define TES_ASSERT_IMP(lbl, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (prop)) \
		else $error(msg);

`endif

// File: hdl/tes_pkg.sv
// Shared types and constants of the timed event scheduler.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package tes_pkg;

	// Fixed field widths of the input word.
	localparam int TIME_W    = 32;
	localparam int IN_TAG_W  = 16;
	localparam int ACT_W     = 2;
	localparam int IN_DATA_W = 120;

	// Input action codes carried on the input tuser.
	localparam logic [ACT_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_REG   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd2;
	localparam logic [ACT_W-1:0] ACT_RUN   = 2'd3;

	// Result kinds carried on the output tuser.
	localparam logic KIND_FIRED  = 1'b0;
	localparam logic KIND_REJECT = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_PICK,
		ST_DIV,
		ST_FLUSH,
		ST_REJ,
		ST_PACK
	} state_t;

endpackage

// File: hdl/tes_div.sv
// Restoring divider producing a fixed-point progress ratio, one quotient bit a cycle.
// Depends on tes_pkg for the time width.
`timescale 1ns / 1ps

module tes_div #(
	parameter int FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tes_pkg::TIME_W-1:0]   dividend,
	input  logic [tes_pkg::TIME_W-1:0]   divisor,
	output logic                         done,
	output logic [FRAC_BITS:0]           quotient
);
	import tes_pkg::*;

	localparam int STEPS = FRAC_BITS + 1;
	localparam int CNT_W = $clog2(STEPS + 1);

	logic                run_q;
	logic                done_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [TIME_W:0]     rem_q;
	logic [TIME_W-1:0]   dvs_q;
	logic [FRAC_BITS:0]  quo_q;
	logic                ge;
	logic [TIME_W:0]     rem_nx;

	// One trial subtraction per cycle.
	assign ge     = rem_q >= {1'b0, dvs_q};
	assign rem_nx = ge ? (rem_q - {1'b0, dvs_q}) : rem_q;

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Partial remainder and quotient shift register.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			dvs_q <= divisor;
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= {rem_nx[TIME_W-1:0], 1'b0};
			quo_q <= {quo_q[FRAC_BITS-1:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// File: hdl/timed_event_scheduler.sv
// Top level of the timed event scheduler: event table memory, walk sequencer, output register.
// Depends on tes_pkg and instantiates tes_div.
`timescale 1ns / 1ps

// Usage:
// The s_ channel takes one word per action (tuser selects tick, register, clear or
// set running). The m_ channel returns one word per fired event or rejected
// registration; tlast marks the final word caused by one input word.
// Register, clear and set running complete on acceptance; a rejected registration
// passes through a reject state to show its word. A tick scans the packed table once
// per fired event plus once per domain walked, each scan going through the registered
// memory read and the pick step, and each event whose span is still open passes
// through the bit-serial divider. A final compaction pass rewrites the surviving
// entries.
// Reset empties the table, zeroes both clocks and pauses simulation time; no
// clearing pass is needed since only entries below the fill count are read.
// When the receiver stalls, the output register holds its word and the walk waits
// before loading the next; the input side accepts only while the sequencer is idle.

module timed_event_scheduler #(
	parameter int TABLE_DEPTH            = 16,
	parameter int TAG_BITS               = 16,
	parameter int PROGRESS_FRACTION_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// tdata: now_ticks, sim_domain, event_tag, begin_time, end_time, run_flag
	input  logic [tes_pkg::IN_DATA_W-1:0]     s_tdata,
	// tuser: action
	input  logic [tes_pkg::ACT_W-1:0]         s_tuser,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// tdata: fired_tag, fired_domain, progress, removed
	output logic [((TAG_BITS + PROGRESS_FRACTION_BITS + 3 + 7) / 8) * 8 - 1:0] m_tdata,
	// tuser: kind
	output logic                              m_tuser,
	output logic                              m_tlast,
	output logic                              m_tvalid,
	input  logic                              m_tready
);
	import tes_pkg::*;

	localparam int IW  = $clog2(TABLE_DEPTH);
	localparam int CW  = $clog2(TABLE_DEPTH + 1);
	localparam int PW  = PROGRESS_FRACTION_BITS + 1;
	localparam int EW  = 1 + TAG_BITS + 2 * TIME_W;
	localparam int ODW = ((TAG_BITS + PW + 2 + 7) / 8) * 8;

	// Input field unpacking.
	logic [TIME_W-1:0]   in_now;
	logic                in_dom;
	logic [TAG_BITS-1:0] in_tag;
	logic [TIME_W-1:0]   in_beg;
	logic [TIME_W-1:0]   in_end;
	logic                in_run;

	assign in_now = s_tdata[31:0];
	assign in_dom = s_tdata[32];
	assign in_tag = TAG_BITS'(s_tdata[48:33]);
	assign in_beg = s_tdata[80:49];
	assign in_end = s_tdata[112:81];
	assign in_run = s_tdata[113];

	state_t state_q, state_d;

	logic [CW-1:0]          used_q;
	logic [TIME_W-1:0]      real_now_q;
	logic [TIME_W-1:0]      sim_now_q;
	logic                   sim_run_q;
	logic                   dom_q;
	logic [TABLE_DEPTH-1:0] seen_q;
	logic [TABLE_DEPTH-1:0] drop_q;
	logic [CW-1:0]          rd_q;
	logic [CW-1:0]          wr_q;
	logic                   rv_s1;
	logic [IW-1:0]          idx_s1;
	logic [EW-1:0]          rdata_s1;
	logic                   found_q;
	logic [IW-1:0]          best_idx_q;
	logic [TIME_W-1:0]      best_beg_q;
	logic [TIME_W-1:0]      best_end_q;
	logic [TAG_BITS-1:0]    best_tag_q;

	logic                   pend_v_q;
	logic                   pend_kind_q;
	logic [TAG_BITS-1:0]    pend_tag_q;
	logic                   pend_dom_q;
	logic [PW-1:0]          pend_prog_q;
	logic                   pend_rem_q;

	logic                   out_v_q;
	logic                   out_kind_q;
	logic                   out_last_q;
	logic [TAG_BITS-1:0]    out_tag_q;
	logic                   out_dom_q;
	logic [PW-1:0]          out_prog_q;
	logic                   out_rem_q;

	logic [EW-1:0] mem [TABLE_DEPTH];

	logic              s_acc;
	logic              out_free;
	logic              full;
	logic [TIME_W-1:0] now_dom;
	logic              pass_end;
	logic              quick;
	logic              out_load;
	logic              out_last;
	logic              scan_init;
	logic              pack_init;
	logic              div_start;
	logic              div_done;
	logic [PW-1:0]     div_quo;
	logic              mem_we;
	logic [IW-1:0]     mem_wa;
	logic [EW-1:0]     mem_wd;

	// Fields of the entry under compare.
	logic                rd_dom;
	logic [TAG_BITS-1:0] rd_tag;
	logic [TIME_W-1:0]   rd_beg;
	logic [TIME_W-1:0]   rd_end;
	logic                cand;

	assign rd_end = rdata_s1[TIME_W-1:0];
	assign rd_beg = rdata_s1[2*TIME_W-1:TIME_W];
	assign rd_tag = rdata_s1[2*TIME_W+TAG_BITS-1:2*TIME_W];
	assign rd_dom = rdata_s1[EW-1];

	assign s_acc    = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !out_v_q || m_tready;
	assign full     = (used_q == CW'(TABLE_DEPTH));
	assign now_dom  = dom_q ? sim_now_q : real_now_q;
	assign pass_end = (rd_q == used_q) && !rv_s1;
	assign quick    = (best_beg_q == best_end_q) || (now_dom > best_end_q);

	// A due entry of the walked domain, not yet fired, earlier than the best so far.
	assign cand = rv_s1 && (rd_dom == dom_q) && !seen_q[idx_s1] && (rd_beg <= now_dom)
		&& (!found_q || (rd_beg < best_beg_q));

	// Next state and sequencing strobes.
	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		out_last  = 1'b0;
		scan_init = 1'b0;
		pack_init = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && s_tuser == ACT_TICK) begin
					state_d   = ST_SCAN;
					scan_init = 1'b1;
				end else if (s_acc && s_tuser == ACT_REG && full) begin
					state_d = ST_REJ;
				end
			end
			ST_SCAN: begin
				if (pass_end) begin
					state_d = ST_PICK;
				end
			end
			ST_PICK: begin
				if (found_q) begin
					if (!pend_v_q || out_free) begin
						out_load = pend_v_q;
						if (quick) begin
							state_d   = ST_SCAN;
							scan_init = 1'b1;
						end else begin
							state_d   = ST_DIV;
							div_start = 1'b1;
						end
					end
				end else if (!dom_q && sim_run_q) begin
					state_d   = ST_SCAN;
					scan_init = 1'b1;
				end else if (pend_v_q) begin
					state_d = ST_FLUSH;
				end else begin
					state_d   = ST_PACK;
					pack_init = 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d   = ST_SCAN;
					scan_init = 1'b1;
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load  = 1'b1;
					out_last  = 1'b1;
					state_d   = ST_PACK;
					pack_init = 1'b1;
				end
			end
			ST_REJ: begin
				if (out_free) begin
					out_load = 1'b1;
					out_last = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_PACK: begin
				if (pass_end) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Clocks, fill count, walk control and pending-result flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			real_now_q <= '0;
			sim_now_q  <= '0;
			sim_run_q  <= 1'b0;
			dom_q      <= 1'b0;
			seen_q     <= '0;
			drop_q     <= '0;
			rd_q       <= '0;
			wr_q       <= '0;
			rv_s1      <= 1'b0;
			found_q    <= 1'b0;
			pend_v_q   <= 1'b0;
		end else begin
			// Actions taken at acceptance.
			if (s_acc) begin
				case (s_tuser)
					ACT_TICK: begin
						real_now_q <= in_now;
						if (sim_run_q) begin
							sim_now_q <= sim_now_q + (in_now - real_now_q);
						end
						dom_q  <= 1'b0;
						seen_q <= '0;
						drop_q <= '0;
					end
					ACT_REG: begin
						if (full) begin
							pend_v_q <= 1'b1;
						end else begin
							used_q <= used_q + CW'(1);
						end
					end
					ACT_CLEAR: begin
						used_q <= '0;
					end
					ACT_RUN: begin
						sim_run_q <= in_run;
					end
					default: begin
					end
				endcase
			end

			// Read pipeline shared by the scan and compaction passes.
			if (scan_init || pack_init) begin
				rd_q    <= '0;
				rv_s1   <= 1'b0;
				found_q <= 1'b0;
			end else if (state_q == ST_SCAN || state_q == ST_PACK) begin
				if (rd_q != used_q) begin
					rd_q  <= rd_q + CW'(1);
					rv_s1 <= 1'b1;
				end else begin
					rv_s1 <= 1'b0;
				end
				if (state_q == ST_SCAN && cand) begin
					found_q <= 1'b1;
				end
			end

			if (pack_init) begin
				wr_q <= '0;
			end else if (state_q == ST_PACK) begin
				if (rv_s1 && !drop_q[idx_s1]) begin
					wr_q <= wr_q + CW'(1);
				end
				if (pass_end) begin
					used_q <= wr_q;
				end
			end

			// Firing the picked event, moving to the simulated domain and tracking the pending result.
			if (state_q == ST_PICK) begin
				if (found_q && (!pend_v_q || out_free)) begin
					seen_q[best_idx_q] <= 1'b1;
					pend_v_q           <= quick;
					if (quick) begin
						drop_q[best_idx_q] <= 1'b1;
					end
				end else if (!found_q && !dom_q && sim_run_q) begin
					dom_q <= 1'b1;
				end
			end
			if (state_q == ST_DIV && div_done) begin
				pend_v_q <= 1'b1;
			end
			if ((state_q == ST_FLUSH || state_q == ST_REJ) && out_free) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Best-candidate and pending-result payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_SCAN || state_q == ST_PACK) begin
			idx_s1 <= rd_q[IW-1:0];
		end
		if (state_q == ST_SCAN && cand) begin
			best_idx_q <= idx_s1;
			best_beg_q <= rd_beg;
			best_end_q <= rd_end;
			best_tag_q <= rd_tag;
		end
		if (s_acc && s_tuser == ACT_REG) begin
			pend_kind_q <= KIND_REJECT;
			pend_tag_q  <= in_tag;
			pend_dom_q  <= in_dom;
			pend_prog_q <= '0;
			pend_rem_q  <= 1'b0;
		end
		if (state_q == ST_PICK && found_q && (!pend_v_q || out_free) && quick) begin
			pend_kind_q <= KIND_FIRED;
			pend_tag_q  <= best_tag_q;
			pend_dom_q  <= dom_q;
			pend_rem_q  <= 1'b1;
			if (best_beg_q == best_end_q) begin
				pend_prog_q <= '0;
			end else begin
				pend_prog_q <= {1'b1, {PROGRESS_FRACTION_BITS{1'b0}}};
			end
		end
		if (state_q == ST_DIV && div_done) begin
			pend_kind_q <= KIND_FIRED;
			pend_tag_q  <= best_tag_q;
			pend_dom_q  <= dom_q;
			pend_rem_q  <= 1'b0;
			pend_prog_q <= div_quo;
		end
	end

	// Progress ratio of the picked event.
	tes_div #(
		.FRAC_BITS (PROGRESS_FRACTION_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (now_dom - best_beg_q),
		.divisor  (best_end_q - best_beg_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Single write port: new entry on registration, survivors during compaction.
	always_comb begin
		mem_we = 1'b0;
		mem_wa = used_q[IW-1:0];
		mem_wd = {in_dom, in_tag, in_beg, in_end};
		if (s_acc && s_tuser == ACT_REG && !full) begin
			mem_we = 1'b1;
		end else if (state_q == ST_PACK && rv_s1 && !drop_q[idx_s1]) begin
			mem_we = 1'b1;
			mem_wa = wr_q[IW-1:0];
			mem_wd = rdata_s1;
		end
	end

	// Event table with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rdata_s1 <= mem[rd_q[IW-1:0]];
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_load) begin
			out_v_q <= 1'b1;
		end else if (m_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= pend_kind_q;
			out_last_q <= out_last;
			out_tag_q  <= pend_tag_q;
			out_dom_q  <= pend_dom_q;
			out_prog_q <= pend_prog_q;
			out_rem_q  <= pend_rem_q;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = ODW'({out_rem_q, out_prog_q, out_dom_q, out_tag_q});

endmodule

// File: hdl/tes_chk.sv
// Port-level checker for the timed event scheduler, bound to the top level.
// Depends on assert_macros.svh and tes_pkg.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module tes_chk #(
	parameter int TAG_BITS  = 16,
	parameter int FRAC_BITS = 16,
	parameter int ODW       = 40
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic [ODW-1:0]                m_tdata,
	input logic                          m_tuser,
	input logic                          m_tlast,
	input logic                          m_tvalid,
	input logic                          m_tready
);
	import tes_pkg::*;

	localparam int PW = FRAC_BITS + 1;

	logic [PW-1:0] prog;
	logic          rem;

	assign prog = m_tdata[TAG_BITS+PW:TAG_BITS+1];
	assign rem  = m_tdata[TAG_BITS+PW+1];

	// A stalled word stays offered.
	`TES_ASSERT(a_hold, m_tvalid && !m_tready |=> m_tvalid, "output word dropped under stall")

	// A rejection is always the last word of its action and is never marked removed.
	`TES_ASSERT_IMP(a_rej_last, m_tvalid && m_tuser == KIND_REJECT, m_tlast && !rem,
		"rejection word not last or marked removed")

	// A removed event reports either zero or complete progress.
	`TES_ASSERT_IMP(a_rem_prog, m_tvalid && m_tuser == KIND_FIRED && rem,
		prog == '0 || prog == {1'b1, {FRAC_BITS{1'b0}}}, "removed event with partial progress")

	// Progress never exceeds one.
	`TES_ASSERT_IMP(a_prog_max, m_tvalid, prog <= {1'b1, {FRAC_BITS{1'b0}}},
		"progress above one")

endmodule

bind timed_event_scheduler tes_chk #(
	.TAG_BITS  (TAG_BITS),
	.FRAC_BITS (PROGRESS_FRACTION_BITS),
	.ODW       (((TAG_BITS + PROGRESS_FRACTION_BITS + 3 + 7) / 8) * 8)
) u_tes_chk (.*);
